@@ design/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the message hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int QueueDepth = 4;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    word_t digest_word;
    logic  last_word;
  } out_item_t;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

@@ design/sha_stream_if.sv @@
// ----------------------------------------------------------------------------
// sha_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface sha_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/sha_front.sv @@
// ----------------------------------------------------------------------------
// sha_front
// Input queue: takes beats and holds them for the compression engine.
// ----------------------------------------------------------------------------
module sha_front
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  sha_stream_if.sink in_ch,
  output logic       item_valid,
  output in_item_t   item,
  input  logic       item_take
);

  localparam int Aw = $clog2(QueueDepth);

  in_item_t          slots [QueueDepth];
  logic [Aw-1:0]     wr_ptr;
  logic [Aw-1:0]     rd_ptr;
  logic [Aw:0]       count;
  logic              push;
  logic              pop;

  assign in_ch.ready = (count != (Aw+1)'(QueueDepth));
  assign push = in_ch.valid && in_ch.ready;
  assign item_valid = (count != '0);
  assign pop = item_valid && item_take;
  assign item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= in_ch.payload;
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= (Aw+1)'(QueueDepth)) else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1)) else $error("count slip");

endmodule

@@ design/sha_engine.sv @@
// ----------------------------------------------------------------------------
// sha_engine
// Block buffering, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
module sha_engine
  import sha_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  in_item_t     item,
  output logic         item_take,
  sha_stream_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_INIT, S_ROUND, S_FOLD, S_EMIT
  } state_t;

  state_t      state;
  word_t       wbuf [16];
  word_t       hv [8];
  word_t       va [8];
  logic [63:0] bit_length;
  logic [5:0]  fill_position;
  logic [5:0]  round;
  logic        pending_end;
  logic        final_blk;
  logic [2:0]  emit_idx;

  word_t wv, t1, t2, w_new;
  word_t byte_word;

  always_comb begin
    w_new = wbuf[0] + ssig0(wbuf[1]) + ssig1(wbuf[14]) + wbuf[9];
    wv = (round < 6'd16) ? wbuf[0] : w_new;
    t1 = va[7] + bsig1(va[4]) + ((va[4] & va[5]) ^ (~va[4] & va[6])) + RoundK[round] + wv;
    t2 = bsig0(va[0]) + ((va[0] & va[1]) ^ (va[0] & va[2]) ^ (va[1] & va[2]));
  end

  assign item_take = (state == S_IDLE);
  assign out_ch.valid = (state == S_EMIT);
  assign out_ch.payload = '{digest_word: hv[emit_idx], last_word: (emit_idx == 3'd7)};

  always_comb begin
    byte_word = wbuf[fill_position[5:2]];
    case (fill_position[1:0])
      2'd0: byte_word[31:24] = item.data_byte;
      2'd1: byte_word[23:16] = item.data_byte;
      2'd2: byte_word[15:8] = item.data_byte;
      default: byte_word[7:0] = item.data_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bit_length <= '0;
      fill_position <= '0;
      pending_end <= 1'b0;
      final_blk <= 1'b0;
      emit_idx <= '0;
      round <= '0;
      for (int i = 0; i < 8; i++) hv[i] <= InitH[i];
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            pending_end <= item.end_of_message;
            if (item.byte_present) begin
              wbuf[fill_position[5:2]] <= byte_word;
              bit_length <= bit_length + 64'd8;
              fill_position <= fill_position + 6'd1;
              if (fill_position == 6'd63) begin
                final_blk <= 1'b0;
                state <= S_INIT;
              end else if (item.end_of_message) state <= S_PAD;
            end else if (item.end_of_message) state <= S_PAD;
          end
        end
        S_PAD: begin
          // place the pad byte, clear the rest, add length when it fits
          for (int i = 0; i < 16; i++) begin
            if (i > fill_position[5:2]) wbuf[i] <= '0;
          end
          case (fill_position[1:0])
            2'd0: wbuf[fill_position[5:2]] <= {PadByte, 24'h0};
            2'd1: wbuf[fill_position[5:2]] <= {wbuf[fill_position[5:2]][31:24], PadByte, 16'h0};
            2'd2: wbuf[fill_position[5:2]] <= {wbuf[fill_position[5:2]][31:16], PadByte, 8'h0};
            default: wbuf[fill_position[5:2]] <= {wbuf[fill_position[5:2]][31:8], PadByte};
          endcase
          if (fill_position < 6'd56) begin
            wbuf[14] <= bit_length[63:32];
            wbuf[15] <= bit_length[31:0];
            final_blk <= 1'b1;
          end else begin
            final_blk <= 1'b0;
          end
          state <= S_INIT;
        end
        S_INIT: begin
          for (int i = 0; i < 8; i++) va[i] <= hv[i];
          round <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) wbuf[i] <= wbuf[i+1];
          wbuf[15] <= wv;
          va[7] <= va[6];
          va[6] <= va[5];
          va[5] <= va[4];
          va[4] <= va[3] + t1;
          va[3] <= va[2];
          va[2] <= va[1];
          va[1] <= va[0];
          va[0] <= t1 + t2;
          round <= round + 6'd1;
          if (round == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) hv[i] <= hv[i] + va[i];
          fill_position <= '0;
          if (final_blk) begin
            emit_idx <= '0;
            state <= S_EMIT;
          end else if (pending_end) begin
            if (fill_position != '0) begin
              // pad overflow: zero block with length
              for (int i = 0; i < 14; i++) wbuf[i] <= '0;
              wbuf[14] <= bit_length[63:32];
              wbuf[15] <= bit_length[31:0];
              final_blk <= 1'b1;
              state <= S_INIT;
            end else begin
              state <= S_PAD;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) hv[i] <= InitH[i];
              bit_length <= '0;
              pending_end <= 1'b0;
              final_blk <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round == 6'd63) |=> (state == S_FOLD)) else $error("round end");
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && emit_idx == 3'd7) |=> (state == S_IDLE))
    else $error("digest end");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> final_blk) else $error("emit without final block");

endmodule

@@ design/sha256_message_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_message_hasher
// Byte-stream SHA-256 hasher with an input queue ahead of the engine.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_ch     in   data_byte, byte_present, end_of_message
//  out_ch    out  digest_word, last_word
//
//  One byte beat per cycle into the buffer while the engine is idle; a full block
//  then goes through load, 64 rounds on the single round unit and fold before the next beat.
//  End of message adds a pad step, one or two blocks, then eight digest beats.
//  Reset empties the queue and restores the initial hash values.
//  Input stalls only when the queue fills; digest beats hold until taken.
module sha256_message_hasher
  import sha_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  sha_stream_if.sink   in_ch,
  sha_stream_if.source out_ch
);

  logic     item_valid;
  logic     item_take;
  in_item_t item;

  sha_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .item_valid(item_valid), .item(item), .item_take(item_take)
  );

  sha_engine u_engine (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item(item),
    .item_take(item_take), .out_ch(out_ch)
  );

endmodule
